// ----- sv/mcdm_pkg.sv -----
`timescale 1ns / 1ps

package mcdm_pkg;

    // Channel count limits and default
    localparam int MAX_CHANNELS     = 4;
    localparam int DEFAULT_CHANNELS = 4;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int CH_W       = 3;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int DEADLINE_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = CMD_W;
    localparam int OUT_FIELD_W = 1 + 1 + COUNT_W + TIME_W + DEADLINE_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE     = 3'd5;

    // Register reset values
    localparam logic [DEADLINE_W-1:0] DEADLINE_RST [MAX_CHANNELS] =
        '{16'd20, 16'd50, 16'd100, 16'd500};
    localparam logic [MAX_CHANNELS-1:0] MASK_RST  = 4'd7;
    localparam logic [TIME_W-1:0]       GRACE_RST = 32'd1000;

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_RESTART  = 2'd0,
        CMD_PROGRESS = 2'd1,
        CMD_CHECK    = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DONE
    } t_state;

    // Result item, lowest field last
    typedef struct packed {
        logic [OUT_PAD_W-1:0]  pad;
        logic                  mandatory_out;
        logic [DEADLINE_W-1:0] deadline_out;
        logic [TIME_W-1:0]     last_time;
        logic [COUNT_W-1:0]    progress_count;
        logic                  healthy;
        logic                  accepted;
    } t_result;

endpackage

// ----- sv/multi_channel_deadline_monitor.sv -----
`timescale 1ns / 1ps

// Heartbeat deadline monitor for up to four channels. Each input transaction
// carries a command in tuser and a channel and millisecond time in tdata;
// exactly one result transaction follows each one. Restart, progress, read and
// a check taken before the startup grace time put their result in the output
// register in the cycle after acceptance; a check taken at or after the grace
// time walks the channels through one shared 32-bit subtract-and-compare, one
// channel per cycle, and its result is registered at the end of the walk. The
// block takes one command at a time: the input is ready again in the cycle
// after the result is taken.
// Configuration writes land at once and should be made while no command is
// in flight.
module multi_channel_deadline_monitor
    import mcdm_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // command stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // channel[2:0], now_time[34:3], zero pad
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // command[1:0]
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // accepted[0], healthy[1],
                                                  // progress_count[33:2], last_time[65:34],
                                                  // deadline_out[81:66], mandatory_out[82],
                                                  // zero pad
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    // State and registers
    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_ok;
    logic [TIME_W-1:0]     r_now;
    t_result               r_res, n_res;

    logic [COUNT_W-1:0]    r_count    [CHANNELS];
    logic [TIME_W-1:0]     r_stamp    [CHANNELS];
    logic [DEADLINE_W-1:0] r_deadline [CHANNELS];
    logic [CHANNELS-1:0]   r_mask;
    logic [TIME_W-1:0]     r_grace;

    // Input decode
    logic                  w_in_accept;
    logic                  w_out_accept;
    t_cmd                  w_cmd;
    logic [CH_W-1:0]       w_ch;
    logic [TIME_W-1:0]     w_now;
    logic                  w_ch_ok;
    logic [IDX_W-1:0]      w_ch_idx;
    logic                  w_in_grace;

    // Shared elapsed-time unit
    logic [TIME_W-1:0]     w_elapsed;
    logic                  w_fail;

    assign w_in_accept  = s_axis_tvalid && s_axis_tready;
    assign w_out_accept = m_axis_tvalid && m_axis_tready;
    assign w_cmd        = t_cmd'(s_axis_tuser[CMD_W-1:0]);
    assign w_ch         = s_axis_tdata[CH_W-1:0];
    assign w_now        = s_axis_tdata[CH_W +: TIME_W];
    assign w_ch_ok      = w_ch < CH_W'(CHANNELS);
    assign w_ch_idx     = w_ch[IDX_W-1:0];
    assign w_in_grace   = w_now < r_grace;

    assign w_elapsed = r_now - r_stamp[r_idx];
    assign w_fail    = r_mask[r_idx] && (w_elapsed > TIME_W'(r_deadline[r_idx]));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_DONE);
    assign m_axis_tdata  = r_res;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_idx = '0;
                    if (w_cmd == CMD_CHECK && !w_in_grace) begin
                        n_state = S_CHECK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CHECK: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_accept) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration, channel records and check flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_count[i]    <= '0;
                r_stamp[i]    <= '0;
                r_deadline[i] <= DEADLINE_RST[i];
            end
            r_mask  <= MASK_RST[CHANNELS-1:0];
            r_grace <= GRACE_RST;
            r_ok    <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx <= REG_DEADLINE3 && i_cfg_idx < CFG_IDX_W'(CHANNELS)) begin
                    r_deadline[i_cfg_idx[IDX_W-1:0]] <= i_cfg_wdata[DEADLINE_W-1:0];
                end else if (i_cfg_idx == REG_MASK) begin
                    r_mask <= i_cfg_wdata[CHANNELS-1:0];
                end else if (i_cfg_idx == REG_GRACE) begin
                    r_grace <= i_cfg_wdata[TIME_W-1:0];
                end
            end
            if (w_in_accept) begin
                r_ok <= 1'b1;
                case (w_cmd)
                    CMD_RESTART: begin
                        for (int i = 0; i < CHANNELS; i++) begin
                            r_count[i] <= '0;
                            r_stamp[i] <= w_now;
                        end
                    end
                    CMD_PROGRESS: begin
                        if (w_ch_ok) begin
                            r_count[w_ch_idx] <= r_count[w_ch_idx] + 1'b1;
                            r_stamp[w_ch_idx] <= w_now;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (r_state == S_CHECK && w_fail) begin
                r_ok <= 1'b0;
            end
        end
    end

    // Next result: built on acceptance, verdict filled in at the end of a walk
    always_comb begin
        n_res = r_res;
        if (w_in_accept) begin
            n_res = '0;
            case (w_cmd)
                CMD_RESTART: begin
                    n_res.accepted = 1'b1;
                end
                CMD_PROGRESS: begin
                    n_res.accepted = w_ch_ok;
                end
                CMD_CHECK: begin
                    n_res.accepted = 1'b1;
                    n_res.healthy  = w_in_grace;
                end
                CMD_READ: begin
                    if (w_ch_ok) begin
                        n_res.accepted       = 1'b1;
                        n_res.progress_count = r_count[w_ch_idx];
                        n_res.last_time      = r_stamp[w_ch_idx];
                        n_res.deadline_out   = r_deadline[w_ch_idx];
                        n_res.mandatory_out  = r_mask[w_ch_idx];
                    end
                end
                default: begin
                end
            endcase
        end else if (r_state == S_CHECK && r_idx == LAST_IDX) begin
            n_res.healthy = r_ok && !w_fail;
        end
    end

    // Result register and latched time
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_in_accept) begin
            r_now <= w_now;
        end
    end

`ifndef SYNTHESIS
    // A check past the grace time starts the walk at channel zero
    a_check_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_cmd == CMD_CHECK && !w_in_grace)
            |=> (r_state == S_CHECK && r_idx == '0))
        else $error("check walk did not start at channel zero");

    // Every other command goes straight to the result register
    a_direct_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && !(w_cmd == CMD_CHECK && !w_in_grace)) |=> m_axis_tvalid)
        else $error("result not presented after a single-cycle command");

    // The walk ends after the last channel
    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && r_idx == LAST_IDX) |=> m_axis_tvalid)
        else $error("check walk ran past the last channel");

    // A healthy verdict is only given on an accepted command
    a_healthy_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_res.healthy) |-> r_res.accepted)
        else $error("healthy flag set on a rejected command");

    // A rejected command carries an all-zero record
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_res.accepted)
            |-> (r_res.progress_count == '0 && r_res.last_time == '0
                 && r_res.deadline_out == '0 && !r_res.mandatory_out))
        else $error("rejected command returned record data");
`endif

endmodule

// ----- verif/multi_channel_deadline_monitor_tb.sv -----
`timescale 1ns / 1ps

module multi_channel_deadline_monitor_tb;
    import mcdm_pkg::*;

    localparam int NCH            = DEFAULT_CHANNELS;
    localparam int SETTLE_CYCLES  = DEFAULT_CHANNELS + 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 140;
    localparam int MAX_PRINTS     = 60;

    // Indexes past the register map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // One row of the directed table
    typedef struct {
        t_cmd        cmd;
        logic [2:0]  ch;
        logic [31:0] now_ms;
        bit          fixed;
        t_result     want;
    } t_row;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata   = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic [IN_TDATA_W-1:0]  in_data     = '0;
    logic [IN_TUSER_W-1:0]  in_user     = '0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [OUT_TDATA_W-1:0] out_data;

    // Predictor state and configuration
    logic [DEADLINE_W-1:0] cfg_deadline [NCH];
    logic [NCH-1:0]        cfg_mask;
    logic [TIME_W-1:0]     cfg_grace;
    logic [COUNT_W-1:0]    hb_count [NCH];
    logic [TIME_W-1:0]     hb_stamp [NCH];

    t_result     due_results [$];
    t_row        dir_rows [$];
    bit          row_fixed = 1'b0;
    t_result     row_want  = '0;
    int          errors    = 0;
    int          result_no = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_order = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;
    int          quiet_cycles = 0;
    logic [31:0] cur_time = '0;

    multi_channel_deadline_monitor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .s_axis_tuser  (in_user),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result rec(input logic acc, input logic ok, input logic [31:0] cnt,
                                    input logic [31:0] stamp, input logic [15:0] dl,
                                    input logic mand);
        t_result r;
        r = '0;
        r.accepted       = acc;
        r.healthy        = ok;
        r.progress_count = cnt;
        r.last_time      = stamp;
        r.deadline_out   = dl;
        r.mandatory_out  = mand;
        return r;
    endfunction

    // Heartbeat supervision: updates the channel state and returns the result
    function automatic t_result supervise(input t_cmd cmd, input logic [2:0] ch,
                                          input logic [31:0] now_ms);
        t_result     r;
        logic [31:0] elapsed;
        r = '0;
        case (cmd)
            CMD_RESTART: begin
                for (int i = 0; i < NCH; i++) begin
                    hb_count[i] = '0;
                    hb_stamp[i] = now_ms;
                end
                r.accepted = 1'b1;
            end
            CMD_PROGRESS: begin
                if (ch < NCH) begin
                    hb_count[ch[1:0]] = hb_count[ch[1:0]] + 1'b1;
                    hb_stamp[ch[1:0]] = now_ms;
                    r.accepted        = 1'b1;
                end
            end
            CMD_CHECK: begin
                r.accepted = 1'b1;
                r.healthy  = 1'b1;
                // before the grace time every check passes
                if (now_ms >= cfg_grace) begin
                    for (int i = 0; i < NCH; i++) begin
                        elapsed = now_ms - hb_stamp[i];
                        if (cfg_mask[i] && elapsed > {16'd0, cfg_deadline[i]})
                            r.healthy = 1'b0;
                    end
                end
            end
            default: begin
                if (ch < NCH) begin
                    r.accepted       = 1'b1;
                    r.progress_count = hb_count[ch[1:0]];
                    r.last_time      = hb_stamp[ch[1:0]];
                    r.deadline_out   = cfg_deadline[ch[1:0]];
                    r.mandatory_out  = cfg_mask[ch[1:0]];
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < MAX_PRINTS)
            $display("result %0d: %s got %0h want %0h", result_no, what, got, want);
        errors++;
    endtask

    // Input and output transactions, sampled at the rising edge
    always @(posedge i_clk) begin
        t_result pred;
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                pred = supervise(t_cmd'(in_user), in_data[2:0], in_data[34:3]);
                due_results.push_back(row_fixed ? row_want : pred);
            end
            if (out_valid && out_ready) begin
                got = t_result'(out_data);
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, 32'd0);
                end else begin
                    want = due_results.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
                    if (got.healthy !== want.healthy)
                        report_mismatch("healthy", 32'(got.healthy), 32'(want.healthy));
                    if (got.progress_count !== want.progress_count)
                        report_mismatch("progress_count", got.progress_count,
                                        want.progress_count);
                    if (got.last_time !== want.last_time)
                        report_mismatch("last_time", got.last_time, want.last_time);
                    if (got.deadline_out !== want.deadline_out)
                        report_mismatch("deadline_out", 32'(got.deadline_out),
                                        32'(want.deadline_out));
                    if (got.mandatory_out !== want.mandatory_out)
                        report_mismatch("mandatory_out", 32'(got.mandatory_out),
                                        32'(want.mandatory_out));
                    if (got.pad !== '0)
                        report_mismatch("pad", 32'(got.pad), 32'd0);
                end
                result_no++;
            end
        end
    end

    // Watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("multi_channel_deadline_monitor: mismatch");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_order) begin
            hold_seen = hold_order;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready = 1'b0;
        end else begin
            out_ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Register write, one per cycle; the predictor follows at once
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = data;
        if (idx <= REG_DEADLINE3)
            cfg_deadline[idx[1:0]] = data[DEADLINE_W-1:0];
        else if (idx == REG_MASK)
            cfg_mask = data[NCH-1:0];
        else if (idx == REG_GRACE)
            cfg_grace = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic [31:0] d0, input logic [31:0] d1,
                             input logic [31:0] d2, input logic [31:0] d3,
                             input logic [31:0] mask, input logic [31:0] grace);
        cfg_write(REG_DEADLINE0, d0);
        cfg_write(REG_DEADLINE0 + 3'd1, d1);
        cfg_write(REG_DEADLINE0 + 3'd2, d2);
        cfg_write(REG_DEADLINE3, d3);
        cfg_write(REG_MASK, mask);
        cfg_write(REG_GRACE, grace);
    endtask

    // Offer one command transaction; starts and ends at a falling edge
    task automatic offer(input t_cmd cmd, input logic [2:0] ch, input logic [31:0] now_ms,
                         input bit fixed, input t_result want);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_user   = cmd;
        in_data   = {5'd0, now_ms, ch};
        row_fixed = fixed;
        row_want  = want;
        in_valid  = 1'b1;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    // Wait for every outstanding result, then let the block settle
    task automatic drain();
        in_valid = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic add_row(input t_cmd cmd, input logic [2:0] ch, input logic [31:0] now_ms,
                           input bit fixed, input t_result want);
        t_row r;
        r.cmd    = cmd;
        r.ch     = ch;
        r.now_ms = now_ms;
        r.fixed  = fixed;
        r.want   = want;
        dir_rows.push_back(r);
    endtask

    // Mostly well-formed heartbeat traffic on an advancing clock, some noise
    task automatic run_phase(input int n, input int step_max, input bit hold_mid,
                             input bit pause_mid);
        int          pick;
        t_cmd        cmd;
        logic [2:0]  ch;
        logic [31:0] now_ms;
        for (int k = 0; k < n; k++) begin
            if (hold_mid && k == 10)
                hold_order++;
            if (pause_mid && k == n / 2)
                drain();
            pick = $urandom_range(99);
            if (k == 0) begin
                cmd    = CMD_RESTART;
                ch     = 3'($urandom_range(7));
                now_ms = cur_time;
            end else if (pick < 8) begin
                cmd    = t_cmd'($urandom_range(3));
                ch     = 3'($urandom_range(7));
                now_ms = $urandom;
            end else begin
                pick = $urandom_range(99);
                cmd  = (pick < 5) ? CMD_RESTART : (pick < 50) ? CMD_PROGRESS :
                       (pick < 80) ? CMD_CHECK : CMD_READ;
                ch   = ($urandom_range(99) < 10) ? 3'($urandom_range(7, 4))
                                                 : 3'($urandom_range(3));
                cur_time = cur_time + $urandom_range(step_max);
                now_ms   = cur_time;
            end
            offer(cmd, ch, now_ms, 1'b0, '0);
        end
    endtask

    initial begin
        int step_max;
        for (int i = 0; i < NCH; i++) begin
            cfg_deadline[i] = DEADLINE_RST[i];
            hb_count[i]     = '0;
            hb_stamp[i]     = '0;
        end
        cfg_mask  = MASK_RST;
        cfg_grace = GRACE_RST;

        // Directed table, reset configuration, all stamps zero at first
        add_row(CMD_READ,     3'd0, 32'd0,         1'b1,
                rec(1'b1, 1'b0, 32'd0, 32'd0, 16'd20, 1'b1));
        add_row(CMD_READ,     3'd3, 32'd0,         1'b1,
                rec(1'b1, 1'b0, 32'd0, 32'd0, 16'd500, 1'b0));
        add_row(CMD_READ,     3'd4, 32'd0,         1'b1, '0);
        add_row(CMD_READ,     3'd7, 32'hFFFF_FFFF, 1'b1, '0);
        add_row(CMD_PROGRESS, 3'd5, 32'd123,       1'b1, '0);
        add_row(CMD_CHECK,    3'd7, 32'd999,       1'b1,
                rec(1'b1, 1'b1, 32'd0, 32'd0, 16'd0, 1'b0));
        add_row(CMD_CHECK,    3'd0, 32'd1000,      1'b1,
                rec(1'b1, 1'b0, 32'd0, 32'd0, 16'd0, 1'b0));
        add_row(CMD_CHECK,    3'd1, 32'd0,         1'b1,
                rec(1'b1, 1'b1, 32'd0, 32'd0, 16'd0, 1'b0));
        add_row(CMD_RESTART,  3'd6, 32'd2000,      1'b1,
                rec(1'b1, 1'b0, 32'd0, 32'd0, 16'd0, 1'b0));
        add_row(CMD_CHECK,    3'd2, 32'd2020,      1'b0, '0);
        add_row(CMD_CHECK,    3'd3, 32'd2021,      1'b0, '0);
        add_row(CMD_PROGRESS, 3'd0, 32'd2021,      1'b1,
                rec(1'b1, 1'b0, 32'd0, 32'd0, 16'd0, 1'b0));
        add_row(CMD_PROGRESS, 3'd1, 32'd2040,      1'b0, '0);
        add_row(CMD_PROGRESS, 3'd2, 32'd2100,      1'b0, '0);
        // stamp ahead of now: elapsed wraps to a huge value
        add_row(CMD_CHECK,    3'd0, 32'd2041,      1'b0, '0);
        add_row(CMD_READ,     3'd0, 32'd2041,      1'b0, '0);
        add_row(CMD_PROGRESS, 3'd3, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(CMD_READ,     3'd3, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(CMD_CHECK,    3'd5, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(CMD_RESTART,  3'd1, 32'hFFFF_FFF0, 1'b1,
                rec(1'b1, 1'b0, 32'd0, 32'd0, 16'd0, 1'b0));
        add_row(CMD_CHECK,    3'd4, 32'd4,         1'b0, '0);
        add_row(CMD_PROGRESS, 3'd2, 32'hAAAA_AAAA, 1'b0, '0);
        add_row(CMD_READ,     3'd2, 32'h5555_5555, 1'b0, '0);
        add_row(CMD_READ,     3'd1, 32'h5555_5555, 1'b0, '0);

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        tx_idle_pct  = 38;
        rx_stall_pct = 38;
        foreach (dir_rows[i])
            offer(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].now_ms,
                  dir_rows[i].fixed, dir_rows[i].want);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            cur_time = $urandom;
            case (phase)
                0: begin
                    // tightest deadlines, no grace
                    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'hF, 32'd0);
                    step_max = 2;
                end
                1: begin
                    // loosest deadlines, grace never ends
                    write_all(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hF, 32'hFFFF_FFFF);
                    step_max = 30000;
                end
                2: begin
                    write_all($urandom_range(200, 10), $urandom_range(200, 10),
                              $urandom_range(200, 10), $urandom_range(200, 10),
                              $urandom_range(15), cur_time + 32'd400);
                    step_max = 60;
                end
                3: begin
                    // nothing mandatory
                    write_all($urandom, $urandom, $urandom, $urandom, 32'd0, 32'd0);
                    step_max = 5000;
                end
                4: begin
                    // wide values are cut to width, spare indexes dropped
                    write_all(32'hDEAD_0010, 32'hBEEF_0040, 32'h1234_0080, 32'hFFFF_0100,
                              32'hFFFF_FFF5, 32'h0000_0000);
                    cfg_write(REG_SPARE_LO, $urandom);
                    cfg_write(REG_SPARE_HI, 32'hFFFF_FFFF);
                    step_max = 50;
                end
                5: begin
                    // run the clock across its wrap
                    cur_time = 32'hFFFF_FC00;
                    write_all($urandom_range(300, 100), $urandom_range(300, 100),
                              $urandom_range(300, 100), $urandom_range(300, 100),
                              32'hF, 32'd0);
                    step_max = 40;
                end
                default: begin
                    write_all($urandom_range(300), $urandom_range(300), $urandom_range(300),
                              $urandom_range(300), $urandom_range(15),
                              ($urandom_range(1) != 0) ? 32'd0
                                                       : cur_time + $urandom_range(2000));
                    step_max = 80;
                end
            endcase
            run_phase(PHASE_ITEMS, step_max, phase == 0, phase == 5);
            drain();
        end

        if (errors == 0 && due_results.size() == 0) begin
            $display("multi_channel_deadline_monitor: match");
        end else begin
            $display("multi_channel_deadline_monitor: mismatch");
        end
        $finish;
    end

endmodule
